[hdl/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FUNC_WIDTH     = 3;
	localparam int STATUS_WIDTH   = 2;
	localparam int FILL_WIDTH_DEF = $clog2(DEPTH_DEF + 1);

	typedef enum logic [FUNC_WIDTH-1:0] {
		FUNC_PUSH_FRONT = 3'd0,
		FUNC_PUSH_BACK  = 3'd1,
		FUNC_POP_FRONT  = 3'd2,
		FUNC_POP_BACK   = 3'd3,
		FUNC_PEEK_FRONT = 3'd4,
		FUNC_PEEK_BACK  = 3'd5
	} func_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// result bookkeeping carried alongside the RAM read
	typedef struct packed {
		logic    rd;
		status_t status;
	} meta_t;

endpackage

[hdl/deq_if.sv]
`timescale 1ns / 1ps

interface deq_req_if #(
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) ();
	logic                            valid;
	logic                            ready;
	logic [deq_pkg::FUNC_WIDTH-1:0]  func;
	logic [DATA_WIDTH-1:0]           data_in;

	modport source (output valid, output func, output data_in, input ready);
	modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface deq_rsp_if #(
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
	parameter int FILL_WIDTH = deq_pkg::FILL_WIDTH_DEF
) ();
	logic                             valid;
	logic                             ready;
	logic [DATA_WIDTH-1:0]            data_out;
	logic [deq_pkg::STATUS_WIDTH-1:0] status;
	logic [FILL_WIDTH-1:0]            fill_after;

	modport source (output valid, output data_out, output status, output fill_after,
		input ready);
	modport sink   (input valid, input data_out, input status, input fill_after,
		output ready);
endinterface

[hdl/deq_ram.sv]
`timescale 1ns / 1ps

module deq_ram #(
	parameter int WIDTH = deq_pkg::DATA_WIDTH_DEF,
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

[hdl/deq_ctrl.sv]
`timescale 1ns / 1ps

module deq_ctrl #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int FW        = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [deq_pkg::FUNC_WIDTH-1:0] func,
	input  logic [DATA_WIDTH-1:0]          data_in,
	input  logic                           rsp_ready,
	output logic                           rsp_valid,
	output deq_pkg::meta_t                 meta_s1,
	output logic [FW-1:0]                  fill_s1,
	output logic                           mem_we,
	output logic                           mem_re,
	output logic [AW-1:0]                  mem_addr,
	output logic [DATA_WIDTH-1:0]          mem_wdata
);

	logic [AW-1:0]  front_q, back_q, front_d, back_d;
	logic [FW-1:0]  fill_q, fill_d;
	logic           rsp_valid_q;
	logic           accept;
	logic           full, empty;
	logic           we_c, re_c;
	logic [AW-1:0]  front_prev, front_next, back_prev, back_next;
	deq_pkg::meta_t meta_c;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (fill_q == FW'(DEPTH));
	assign empty     = (fill_q == '0);

	assign front_prev = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_next = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign back_prev  = (back_q == '0) ? AW'(DEPTH - 1) : back_q - AW'(1);
	assign back_next  = (back_q == AW'(DEPTH - 1)) ? '0 : back_q + AW'(1);

	always_comb begin
		front_d       = front_q;
		back_d        = back_q;
		fill_d        = fill_q;
		we_c          = 1'b0;
		re_c          = 1'b0;
		mem_addr      = front_q;
		meta_c.status = deq_pkg::STATUS_OK;
		case (deq_pkg::func_t'(func))
			deq_pkg::FUNC_PUSH_FRONT: begin
				if (full) begin
					meta_c.status = deq_pkg::STATUS_FULL;
				end else begin
					mem_addr = front_prev;
					front_d  = front_prev;
					fill_d   = fill_q + FW'(1);
					we_c     = 1'b1;
				end
			end
			deq_pkg::FUNC_PUSH_BACK: begin
				if (full) begin
					meta_c.status = deq_pkg::STATUS_FULL;
				end else begin
					mem_addr = back_q;
					back_d   = back_next;
					fill_d   = fill_q + FW'(1);
					we_c     = 1'b1;
				end
			end
			deq_pkg::FUNC_POP_FRONT: begin
				if (empty) begin
					meta_c.status = deq_pkg::STATUS_EMPTY;
				end else begin
					mem_addr = front_q;
					front_d  = front_next;
					fill_d   = fill_q - FW'(1);
					re_c     = 1'b1;
				end
			end
			deq_pkg::FUNC_POP_BACK: begin
				if (empty) begin
					meta_c.status = deq_pkg::STATUS_EMPTY;
				end else begin
					mem_addr = back_prev;
					back_d   = back_prev;
					fill_d   = fill_q - FW'(1);
					re_c     = 1'b1;
				end
			end
			deq_pkg::FUNC_PEEK_FRONT: begin
				if (empty) begin
					meta_c.status = deq_pkg::STATUS_EMPTY;
				end else begin
					mem_addr = front_q;
					re_c     = 1'b1;
				end
			end
			deq_pkg::FUNC_PEEK_BACK: begin
				if (empty) begin
					meta_c.status = deq_pkg::STATUS_EMPTY;
				end else begin
					mem_addr = back_prev;
					re_c     = 1'b1;
				end
			end
			default: begin
				// unused codes leave everything alone
			end
		endcase
		meta_c.rd = re_c;
	end

	assign mem_we    = accept && we_c;
	assign mem_re    = accept && re_c;
	assign mem_wdata = data_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				front_q <= front_d;
				back_q  <= back_d;
				fill_q  <= fill_d;
			end
			if (req_ready) begin
				rsp_valid_q <= req_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_c;
			fill_s1 <= fill_d;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[hdl/double_ended_queue.sv]
`timescale 1ns / 1ps

// Bounded double-ended queue in a ring buffer of DEPTH words.
// Channel req (sink): func selects push front/back, pop front/back or
// peek front/back; data_in is the word stored by a push.
// Channel rsp (source): one result per request with data_out (word taken
// or seen, zero otherwise), status (ok, empty error, full error) and
// fill_after, the word count once the request has taken effect.
// The result is valid in the cycle after the request transfer.
// Throughput: one request per cycle while rsp is taken every cycle; each
// request uses the single RAM port at most once and the read data lands in the
// RAM output register, which serves as the result stage.
// When rsp stalls the pending result holds and req.ready drops until it
// is transferred; no request is lost or reordered.
// Reset empties the queue (pointers and count cleared) and drops any
// pending result; the stored words are not cleared and need no sweep.
// A push into a full queue or a pop/peek of an empty queue changes nothing.
module double_ended_queue #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int FW        = $clog2(DEPTH + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_addr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
	deq_pkg::meta_t        meta_s1;
	logic [FW-1:0]         fill_s1;
	logic                  rsp_valid;

	deq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.func      (req.func),
		.data_in   (req.data_in),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp_valid),
		.meta_s1   (meta_s1),
		.fill_s1   (fill_s1),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata)
	);

	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign rsp.valid      = rsp_valid;
	assign rsp.data_out   = meta_s1.rd ? mem_rdata : '0;
	assign rsp.status     = meta_s1.status;
	assign rsp.fill_after = fill_s1;

	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("RAM written and read in the same cycle");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> rsp_valid && meta_s1.rd)
		else $error("RAM read without a result the next cycle");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && meta_s1.status == deq_pkg::STATUS_FULL |-> fill_s1 == FW'(DEPTH))
		else $error("full error reported below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && meta_s1.status == deq_pkg::STATUS_EMPTY |-> fill_s1 == '0)
		else $error("empty error reported with words stored");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> fill_s1 <= FW'(DEPTH))
		else $error("fill count above capacity");

endmodule
